@@ rtl/core/rps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_pkg: shared types and constants for the random permutation shuffle
// Field widths, reset values and the controller/datapath command and status
// structs.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int NODE_COUNT_W      = 9;
    localparam int RANDOM_W          = 31;
    localparam int NODE_INDEX_W      = 8;
    localparam int DEFAULT_MAX_NODES = 256;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

    // Controller to datapath.
    typedef struct packed {
        logic restart;   // configuration write: restart the clearing pass
        logic clr_step;  // write one identity entry
        logic accept;    // latch random word, start the modulo
        logic div_step;  // one restoring-modulo step
        logic rd_issue;  // read selected slot and top live slot
        logic wr_swap;   // move top entry into slot, load result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;  // clearing pass writes its final entry this cycle
        logic div_done;  // this modulo step is the final one
        logic is_last;   // current item empties the pool
        logic out_free;  // result register can take a new result
    } t_dp_status;

endpackage

@@ rtl/core/rps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_if: valid/ready channels of the random permutation shuffle
// Input channel carries the random word, output channel the node index.
// ----------------------------------------------------------------------------
interface rps_in_if;
    logic                         valid;
    logic                         ready;
    logic [rps_pkg::RANDOM_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

interface rps_out_if;
    logic                             valid;
    logic                             ready;
    logic [rps_pkg::NODE_INDEX_W-1:0] node_index;
    logic                             last_of_permutation;

    modport source (output valid, output node_index, output last_of_permutation,
                    input ready);
    modport sink   (input valid, input node_index, input last_of_permutation,
                    output ready);
endinterface

@@ rtl/core/rps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_ctrl: sequencer of the random permutation shuffle
// Steps the datapath through clear, accept, modulo, read and swap.
// ----------------------------------------------------------------------------
module rps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rps_pkg::t_dp_status i_status,
    output rps_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Refuse items on a configuration write cycle.
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_wr_en;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.restart = i_cfg_wr_en;
        unique case (r_state)
            S_CLEAR: begin
                if (!i_cfg_wr_en) begin
                    o_cmd.clr_step = 1'b1;
                    if (i_status.clr_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_WRITE;
            end
            S_WRITE: begin
                // Hold here while the previous result is still waiting.
                if (i_status.out_free) begin
                    o_cmd.wr_swap = 1'b1;
                    n_state       = i_status.is_last ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/rps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_datapath: pool memory, modulo unit and result register
// Restoring modulo one bit per cycle, pool read, swap write and identity fill.
// ----------------------------------------------------------------------------
module rps_datapath #(
    parameter int MAX_NODES = rps_pkg::DEFAULT_MAX_NODES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [rps_pkg::NODE_COUNT_W-1:0]    i_cfg_wr_data,
    input  logic [rps_pkg::RANDOM_W-1:0]        i_random_value,
    input  rps_pkg::t_dp_cmd                    i_cmd,
    output rps_pkg::t_dp_status                 o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rps_pkg::NODE_INDEX_W-1:0]    o_node_index,
    output logic                                o_last_of_permutation
);

    localparam int CW = rps_pkg::NODE_COUNT_W;
    localparam int RW = rps_pkg::RANDOM_W;
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int BW = $clog2(RW);

    logic [AW-1:0] pool [MAX_NODES];

    logic [CW-1:0] r_node_count;
    logic [CW-1:0] r_remaining;
    logic [CW-1:0] r_clr_cnt;
    logic [RW-1:0] r_random;
    logic [CW-1:0] r_rem;
    logic [BW-1:0] r_bit_cnt;
    logic [AW-1:0] r_rd_slot;
    logic [AW-1:0] r_rd_top;
    logic          r_out_valid;
    logic [rps_pkg::NODE_INDEX_W-1:0] r_node_index;
    logic          r_last;

    logic [CW-1:0] w_eff;
    logic [CW:0]   w_trial;
    logic [CW:0]   w_divisor;
    logic          w_remaining_bad;
    logic [AW-1:0] w_slot_addr;
    logic [AW-1:0] w_top_addr;
    logic [AW-1:0] w_clr_addr;

    // Zero acts as one, oversize saturates to the pool depth.
    always_comb begin
        if (r_node_count == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            w_eff = CW'(MAX_NODES);
        end else begin
            w_eff = r_node_count;
        end
    end

    assign w_remaining_bad = (r_remaining == '0) || (r_remaining > w_eff);
    assign w_trial         = {r_rem, r_random[RW-1]};
    assign w_divisor       = {1'b0, r_remaining};
    assign w_slot_addr     = AW'(r_rem);
    assign w_top_addr      = AW'(r_remaining - CW'(1));
    assign w_clr_addr      = AW'(r_clr_cnt);

    assign o_status.clr_last = (r_clr_cnt == (w_eff - CW'(1)));
    assign o_status.div_done = (r_bit_cnt == '0);
    assign o_status.is_last  = (r_remaining == CW'(1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_node_index          = r_node_index;
    assign o_last_of_permutation = r_last;

    // Pool memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            pool[w_clr_addr] <= w_clr_addr;
        end else if (i_cmd.wr_swap) begin
            pool[w_slot_addr] <= r_rd_top;
        end
        if (i_cmd.rd_issue) begin
            r_rd_slot <= pool[w_slot_addr];
            r_rd_top  <= pool[w_top_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= rps_pkg::NODE_COUNT_RESET;
            r_remaining  <= '0;
            r_clr_cnt    <= '0;
            r_bit_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
            if (i_cmd.restart) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
                if (o_status.clr_last) begin
                    r_remaining <= w_eff;
                end
            end
            if (i_cmd.accept) begin
                r_bit_cnt <= BW'(RW - 1);
                if (w_remaining_bad) begin
                    r_remaining <= w_eff;
                end
            end else if (i_cmd.div_step) begin
                r_bit_cnt <= r_bit_cnt - BW'(1);
            end
            if (i_cmd.wr_swap) begin
                r_out_valid <= 1'b1;
                if (o_status.is_last) begin
                    r_clr_cnt <= '0;
                end else begin
                    r_remaining <= r_remaining - CW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: modulo and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_random <= i_random_value;
            r_rem    <= '0;
        end else if (i_cmd.div_step) begin
            r_random <= {r_random[RW-2:0], 1'b0};
            if (w_trial >= w_divisor) begin
                r_rem <= CW'(w_trial - w_divisor);
            end else begin
                r_rem <= CW'(w_trial);
            end
        end
        if (i_cmd.wr_swap) begin
            r_node_index <= rps_pkg::NODE_INDEX_W'(r_rd_slot);
            r_last       <= o_status.is_last;
        end
    end

endmodule

@@ rtl/core/random_permutation_shuffle.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_shuffle: Fisher-Yates permutation generator
// Emits a random ordering of indices 0..n-1, n = node_count (0 as 1, at most
// MAX_NODES), one per random word, drawing from a shrinking on-chip pool.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    random_value[30:0]
//  o_out     out  valid / ready    node_index[7:0], last_of_permutation
//  cfg       in   i_cfg_wr_en      i_cfg_wr_data[8:0] = node_count
//
// Each transaction accepts the random word, runs the bit-serial modulo of it
// by the remaining count, reads the pool (both read ports), then swaps and
// loads the result register.
// After reset, after every node_count write and after the last index of a
// permutation, a clearing pass writes the identity order into the pool, one
// entry per cycle up to the effective count; no input is taken meanwhile.
// A stalled output holds the swap step until the result register frees; a
// new input is taken while a finished result still waits.
// ----------------------------------------------------------------------------
module random_permutation_shuffle #(
    parameter int MAX_NODES = rps_pkg::DEFAULT_MAX_NODES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rps_pkg::NODE_COUNT_W-1:0] i_cfg_wr_data,
    rps_in_if.sink                           i_in,
    rps_out_if.source                        o_out
);

    rps_pkg::t_dp_cmd    w_cmd;
    rps_pkg::t_dp_status w_status;
    logic                w_in_ready;
    logic                w_out_valid;
    logic [rps_pkg::NODE_INDEX_W-1:0] w_node_index;
    logic                w_last;

    // Sequencer: owns the input handshake, drives the datapath.
    rps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: node_count register, pool memory, modulo unit, result.
    rps_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_wr_data         (i_cfg_wr_data),
        .i_random_value        (i_in.random_value),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .o_out_valid           (w_out_valid),
        .i_out_ready           (o_out.ready),
        .o_node_index          (w_node_index),
        .o_last_of_permutation (w_last)
    );

    assign i_in.ready                = w_in_ready;
    assign o_out.valid               = w_out_valid;
    assign o_out.node_index          = w_node_index;
    assign o_out.last_of_permutation = w_last;

endmodule

@@ rtl/core/rps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_checker: port-level checks for the random permutation shuffle
// Watches the handshakes and configuration port of the top level.
// ----------------------------------------------------------------------------
module rps_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_wr_en,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [rps_pkg::NODE_INDEX_W-1:0]   i_node_index,
    input logic                               i_last_of_permutation
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_node_index)
            && $stable(i_last_of_permutation))
        else $error("result changed or dropped while stalled");

    // An accepted transaction keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted transaction");

    // A configuration write starts the clearing pass.
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !i_in_ready)
        else $error("input ready right after a configuration write");

    // No transaction is taken in the cycle of a configuration write.
    a_no_accept_on_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> !i_in_ready)
        else $error("input taken during a configuration write");

endmodule

bind random_permutation_shuffle rps_checker u_rps_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_cfg_wr_en           (i_cfg_wr_en),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_node_index          (o_out.node_index),
    .i_last_of_permutation (o_out.last_of_permutation)
);
